// ===== design/dqs_pkg.sv =====
// Shared types and constants for the deque with linear search.
`default_nettype none

package dqs_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 4;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_REM_FRONT = 2'd2,
    CMD_SEARCH    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam logic signed [VAL_W-1:0] NONE_VALUE = '1;

  typedef struct packed {
    cmd_t                    command;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] removed_value;
    logic [POS_W-1:0]        position;
  } out_rsp_t;

endpackage

`default_nettype wire

// ===== design/deque_with_linear_search.sv =====
// Deque of signed 32-bit values in a ring RAM, with front/back insert, front remove and search.
`default_nettype none

// One request is worked at a time; each gives exactly one response. An insert
// writes the RAM in the accept cycle; every response passes through a result
// stage and then the output register. A removal reads the front entry through
// the RAM's registered read port. A search streams the live entries through
// that read port, one per cycle, front to back, and stops at the first match
// or after the back entry; an empty deque is answered without a search. A new
// request is taken while the previous response waits in the output register on
// out_ready, but not while a response still waits in the result stage.
// DEPTH may be any value from 2 to 16, as positions are reported in 4 bits.

module deque_with_linear_search #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dqs_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dqs_pkg::out_rsp_t      out_data
);

  localparam int AW  = $clog2(DEPTH);
  localparam int AW1 = AW + 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PW  = dqs_pkg::POS_W;
  localparam int VW  = dqs_pkg::VAL_W;
  localparam logic [AW-1:0]  LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0]  FULL_CNT = CW'(DEPTH);
  localparam logic [AW1-1:0] WRAP_SUM = AW1'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RMV  = 3'b010,
    S_SRCH = 3'b100
  } state_t;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    ring_inc = (a == LAST_IDX) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
    ring_dec = (a == '0) ? LAST_IDX : a - AW'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [VW-1:0]     key_r, key_nxt;
  logic              res_valid_r, res_valid_nxt;
  dqs_pkg::out_rsp_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  dqs_pkg::out_rsp_t out_r;

  logic          in_fire;
  logic          res_done;
  logic          res_move;
  logic          is_full;
  logic          is_empty;
  logic          is_last;
  logic [AW1-1:0] back_sum;
  logic [AW-1:0] back_pos;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  dqs_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE) && !res_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);
  assign is_last  = (CW'(idx_r) + CW'(1)) == count_r;
  assign back_sum = AW1'(front_r) + AW1'(count_r);
  assign back_pos = (back_sum >= WRAP_SUM) ? AW'(back_sum - WRAP_SUM) : AW'(back_sum);

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    ptr_nxt   = ptr_r;
    key_nxt   = key_r;
    ram_we    = 1'b0;
    ram_waddr = front_r;
    ram_raddr = front_r;
    res_done  = 1'b0;
    res_nxt   = res_r;
    res_nxt.status        = dqs_pkg::ST_OK;
    res_nxt.removed_value = dqs_pkg::NONE_VALUE;
    res_nxt.position      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.command)
            dqs_pkg::CMD_INS_FRONT: begin
              res_done = 1'b1;
              if (is_full) begin
                res_nxt.status = dqs_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_dec(front_r);
                front_nxt = ring_dec(front_r);
                count_nxt = count_r + CW'(1);
              end
            end
            dqs_pkg::CMD_INS_BACK: begin
              res_done = 1'b1;
              if (is_full) begin
                res_nxt.status = dqs_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = back_pos;
                count_nxt = count_r + CW'(1);
              end
            end
            dqs_pkg::CMD_REM_FRONT: begin
              if (is_empty) begin
                res_done       = 1'b1;
                res_nxt.status = dqs_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_RMV;
              end
            end
            dqs_pkg::CMD_SEARCH: begin
              if (is_empty) begin
                res_done       = 1'b1;
                res_nxt.status = dqs_pkg::ST_NOTFOUND;
              end else begin
                key_nxt   = in_data.value;
                idx_nxt   = '0;
                ptr_nxt   = ring_inc(front_r);
                state_nxt = S_SRCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_RMV: begin
        res_done              = 1'b1;
        res_nxt.removed_value = ram_rdata;
        front_nxt             = ring_inc(front_r);
        count_nxt             = count_r - CW'(1);
        state_nxt             = S_IDLE;
      end
      S_SRCH: begin
        ram_raddr = ptr_r;
        if (ram_rdata == key_r) begin
          res_done         = 1'b1;
          res_nxt.position = PW'(idx_r);
          state_nxt        = S_IDLE;
        end else if (is_last) begin
          res_done       = 1'b1;
          res_nxt.status = dqs_pkg::ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
          ptr_nxt = ring_inc(ptr_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_move      = res_valid_r && (!out_valid_r || out_ready);
  assign res_valid_nxt = res_done || (res_valid_r && !res_move);
  assign out_valid_nxt = res_move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
    if (res_done) begin
      res_r <= res_nxt;
    end
    if (res_move) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count exceeds depth");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !ram_we)
    else $error("RAM write while a removal or search is in flight");

  a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_done |-> !res_valid_r)
    else $error("response produced while result stage still full");

  a_srch_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (CW'(idx_r) < count_r))
    else $error("search index outside live entries");
`endif

endmodule

`default_nettype wire

// ===== design/dqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the deque with linear search against a local predictor.
`default_nettype none

module tb;

  localparam int RING_DEPTH = 16;
  localparam int REQ_TOTAL  = 1300;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 250;
  localparam int CALM_FROM  = 600;
  localparam int CALM_TO    = 900;
  localparam int PRINT_CAP  = 50;
  localparam int VW         = dqs_pkg::VAL_W;
  localparam int PW         = dqs_pkg::POS_W;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  dqs_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  dqs_pkg::out_rsp_t out_data;

  deque_with_linear_search #(.DEPTH(RING_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dqs_pkg::in_req_t     req_backlog[$];
  dqs_pkg::out_rsp_t    rsp_expected[$];
  logic signed [VW-1:0] recent_vals[$];

  logic signed [VW-1:0] ring_vals[RING_DEPTH];
  logic [PW-1:0]        head_idx = '0;
  int                   live_cnt = 0;

  int offer_cnt = 0;
  int taken_cnt = 0;
  int rsp_cnt = 0;
  int bad_cnt = 0;
  int ins_cnt = 0, rem_cnt = 0, srch_cnt = 0;
  int full_cnt = 0, empty_cnt = 0, miss_cnt = 0, hit_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  wire calm = (taken_cnt >= CALM_FROM) && (taken_cnt < CALM_TO);

  function automatic dqs_pkg::out_rsp_t deque_apply(dqs_pkg::in_req_t r);
    dqs_pkg::out_rsp_t rsp;
    logic [PW-1:0]     slot;
    bit                found;
    rsp.status        = dqs_pkg::ST_OK;
    rsp.removed_value = dqs_pkg::NONE_VALUE;
    rsp.position      = '0;
    found             = 1'b0;
    case (r.command)
      dqs_pkg::CMD_INS_FRONT: begin
        if (live_cnt >= RING_DEPTH) begin
          rsp.status = dqs_pkg::ST_FULL;
        end else begin
          head_idx = head_idx - 1'b1;
          ring_vals[head_idx] = r.value;
          live_cnt++;
        end
      end
      dqs_pkg::CMD_INS_BACK: begin
        if (live_cnt >= RING_DEPTH) begin
          rsp.status = dqs_pkg::ST_FULL;
        end else begin
          slot = head_idx + PW'(live_cnt);
          ring_vals[slot] = r.value;
          live_cnt++;
        end
      end
      dqs_pkg::CMD_REM_FRONT: begin
        if (live_cnt == 0) begin
          rsp.status = dqs_pkg::ST_EMPTY;
        end else begin
          rsp.removed_value = ring_vals[head_idx];
          head_idx = head_idx + 1'b1;
          live_cnt--;
        end
      end
      default: begin
        for (int i = 0; i < live_cnt; i++) begin
          slot = head_idx + PW'(i);
          if (!found && ring_vals[slot] == r.value) begin
            found = 1'b1;
            rsp.position = PW'(i);
          end
        end
        if (!found) rsp.status = dqs_pkg::ST_NOTFOUND;
      end
    endcase
    return rsp;
  endfunction

  task automatic note_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
    bad_cnt++;
    if (bad_cnt <= PRINT_CAP)
      $display("ERROR response %0d %s: got %h, want %h", rsp_cnt, what, got, want);
  endtask

  always @(posedge clk) begin
    dqs_pkg::out_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rsp_expected.size() == 0) begin
          note_mismatch("unexpected", VW'(out_data.status), '0);
        end else begin
          want = rsp_expected.pop_front();
          if (out_data.status !== want.status)
            note_mismatch("status", VW'(out_data.status), VW'(want.status));
          if (out_data.removed_value !== want.removed_value)
            note_mismatch("removed_value", out_data.removed_value, want.removed_value);
          if (out_data.position !== want.position)
            note_mismatch("position", VW'(out_data.position), VW'(want.position));
        end
        rsp_cnt++;
      end
      if (in_valid && in_ready) begin
        want = deque_apply(in_data);
        rsp_expected.push_back(want);
        taken_cnt++;
        case (in_data.command)
          dqs_pkg::CMD_REM_FRONT: rem_cnt++;
          dqs_pkg::CMD_SEARCH:    srch_cnt++;
          default:                ins_cnt++;
        endcase
        case (want.status)
          dqs_pkg::ST_FULL:     full_cnt++;
          dqs_pkg::ST_EMPTY:    empty_cnt++;
          dqs_pkg::ST_NOTFOUND: miss_cnt++;
          default:              if (in_data.command == dqs_pkg::CMD_SEARCH) hit_cnt++;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken_cnt == offer_cnt)) begin
      if (req_backlog.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        in_data   <= req_backlog.pop_front();
        in_valid  <= 1'b1;
        offer_cnt = offer_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && taken_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  function automatic logic signed [VW-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom;
    if (sel < 70) return VW'($signed($urandom_range(8)) - 4);
    if (sel < 85 || recent_vals.size() == 0) begin
      case ($urandom_range(3))
        0:       return {1'b1, {(VW-1){1'b0}}};
        1:       return {1'b0, {(VW-1){1'b1}}};
        2:       return dqs_pkg::NONE_VALUE;
        default: return '0;
      endcase
    end
    return recent_vals[$urandom_range(recent_vals.size() - 1)];
  endfunction

  task automatic queue_req(dqs_pkg::cmd_t c, logic signed [VW-1:0] v);
    dqs_pkg::in_req_t r;
    r.command = c;
    r.value   = v;
    req_backlog.push_back(r);
    if (c == dqs_pkg::CMD_INS_FRONT || c == dqs_pkg::CMD_INS_BACK) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > 24) void'(recent_vals.pop_front());
    end
  endtask

  initial begin
    int                   mode;
    int                   burst;
    int                   roll;
    dqs_pkg::cmd_t        c;
    dqs_pkg::cmd_t        c_ins;
    logic signed [VW-1:0] v;

    queue_req(dqs_pkg::CMD_REM_FRONT, $urandom);
    queue_req(dqs_pkg::CMD_SEARCH,    dqs_pkg::NONE_VALUE);
    queue_req(dqs_pkg::CMD_INS_BACK,  {1'b0, {(VW-1){1'b1}}});
    queue_req(dqs_pkg::CMD_INS_FRONT, {1'b1, {(VW-1){1'b0}}});
    queue_req(dqs_pkg::CMD_SEARCH,    dqs_pkg::NONE_VALUE);
    queue_req(dqs_pkg::CMD_INS_BACK,  dqs_pkg::NONE_VALUE);
    queue_req(dqs_pkg::CMD_INS_FRONT, '0);
    queue_req(dqs_pkg::CMD_SEARCH,    dqs_pkg::NONE_VALUE);
    queue_req(dqs_pkg::CMD_SEARCH,    {1'b1, {(VW-1){1'b0}}});
    queue_req(dqs_pkg::CMD_SEARCH,    {1'b0, {(VW-1){1'b1}}});
    queue_req(dqs_pkg::CMD_SEARCH,    '0);
    queue_req(dqs_pkg::CMD_SEARCH,    32'sd5);
    queue_req(dqs_pkg::CMD_REM_FRONT, '0);
    queue_req(dqs_pkg::CMD_REM_FRONT, '1);
    queue_req(dqs_pkg::CMD_REM_FRONT, $urandom);
    queue_req(dqs_pkg::CMD_REM_FRONT, $urandom);
    queue_req(dqs_pkg::CMD_REM_FRONT, $urandom);
    queue_req(dqs_pkg::CMD_SEARCH,    '0);

    while (req_backlog.size() < REQ_TOTAL) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(30, 8);
      repeat (burst) begin
        roll  = $urandom_range(99);
        c_ins = (roll & 1) ? dqs_pkg::CMD_INS_BACK : dqs_pkg::CMD_INS_FRONT;
        case (mode)
          0:       c = (roll < 80) ? c_ins :
                       (roll < 90) ? dqs_pkg::CMD_REM_FRONT : dqs_pkg::CMD_SEARCH;
          1:       c = (roll < 75) ? dqs_pkg::CMD_REM_FRONT :
                       (roll < 90) ? dqs_pkg::CMD_SEARCH : c_ins;
          default: c = (roll < 50) ? dqs_pkg::CMD_SEARCH :
                       (roll < 75) ? dqs_pkg::CMD_REM_FRONT : c_ins;
        endcase
        if (c == dqs_pkg::CMD_SEARCH && recent_vals.size() > 0 && $urandom_range(99) < 60)
          v = recent_vals[$urandom_range(recent_vals.size() - 1)];
        else
          v = pick_value();
        queue_req(c, v);
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() > 0 || in_valid || rsp_expected.size() > 0)
      @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Covered %0d requests: %0d inserts, %0d removals, %0d searches (%0d hits).",
             taken_cnt, ins_cnt, rem_cnt, srch_cnt, hit_cnt);
    $display("Checked %0d responses; %0d full refusals, %0d empty removals, %0d misses.",
             rsp_cnt, full_cnt, empty_cnt, miss_cnt);
    if (bad_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Timeout with %0d responses outstanding", rsp_expected.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
